[src/rmhts_pkg.sv]
// Shared types and codes for the ring motor homing and turn sequencer.
// No dependencies; all other files but rmhts_if import this package.
package rmhts_pkg;

    // event codes carried by the operation field
    typedef enum logic [2:0] {
        OP_STEP_DONE = 3'd0,
        OP_HOME      = 3'd1,
        OP_CALIBRATE = 3'd2,
        OP_TURN      = 3'd3,
        OP_HOUR_TICK = 3'd4,
        OP_RESET     = 3'd5
    } op_t;

    // status codes reported in each result word
    localparam logic [2:0] STATUS_IDLE  = 3'd0;
    localparam logic [2:0] STATUS_HOME  = 3'd1;
    localparam logic [2:0] STATUS_CAL   = 3'd2;
    localparam logic [2:0] STATUS_TURN  = 3'd3;
    localparam logic [2:0] STATUS_ERROR = 3'd4;

    // configuration register indexes
    localparam logic [2:0] REG_WORK_MODE      = 3'd0;
    localparam logic [2:0] REG_STEP_LIMIT     = 3'd1;
    localparam logic [2:0] REG_PAUSE_POSITION = 3'd2;
    localparam logic [2:0] REG_PAUSE_ONE_MS   = 3'd3;
    localparam logic [2:0] REG_PAUSE_TWO_MS   = 3'd4;
    localparam logic [2:0] REG_HOUR_BEGIN     = 3'd5;
    localparam logic [2:0] REG_HOUR_END       = 3'd6;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    // hour value that matches no real hour
    localparam logic [4:0] NO_HOUR = 5'd31;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_HOME  = 5'b00010,
        S_CAL   = 5'b00100,
        S_TURN  = 5'b01000,
        S_ERROR = 5'b10000
    } mode_t;

    typedef struct packed {
        logic        work_mode;
        logic [15:0] step_limit;
        logic [7:0]  pause_position;
        logic [15:0] pause_one_ms;
        logic [15:0] pause_two_ms;
        logic [4:0]  hour_begin;
        logic [4:0]  hour_end;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic        sensor_hit;
        logic [15:0] turn_count;
        logic [4:0]  clock_hour;
        logic [5:0]  clock_minute;
    } cmd_t;

    typedef struct packed {
        logic        step_request;
        logic [15:0] step_delay_ms;
        logic        motor_enable;
        logic        sensor_led;
        logic [2:0]  status;
        logic [15:0] steps_per_turn;
        logic [15:0] turns_left;
    } rsp_t;

endpackage

[src/rmhts_if.sv]
// Valid/ready channel interfaces for the sequencer's event and result words.
// Field widths follow the cmd_t and rsp_t structs of rmhts_pkg.
interface rmhts_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic        sensor_hit;
    logic [15:0] turn_count;
    logic [4:0]  clock_hour;
    logic [5:0]  clock_minute;

    modport source (output valid, operation, sensor_hit, turn_count, clock_hour,
                    clock_minute, input ready);
    modport sink (input valid, operation, sensor_hit, turn_count, clock_hour,
                  clock_minute, output ready);
endinterface

interface rmhts_rsp_if;
    logic        valid;
    logic        ready;
    logic        step_request;
    logic [15:0] step_delay_ms;
    logic        motor_enable;
    logic        sensor_led;
    logic [2:0]  status;
    logic [15:0] steps_per_turn;
    logic [15:0] turns_left;

    modport source (output valid, step_request, step_delay_ms, motor_enable, sensor_led,
                    status, steps_per_turn, turns_left, input ready);
    modport sink (input valid, step_request, step_delay_ms, motor_enable, sensor_led,
                  status, steps_per_turn, turns_left, output ready);
endinterface

[src/rmhts_cfg_regs.sv]
// Configuration register bank of the sequencer, written through a plain write port.
// Depends on rmhts_pkg for the register indexes and the cfg_t struct.
module rmhts_cfg_regs
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    wr_en,
    input  logic [rmhts_pkg::CFG_INDEX_W-1:0]       wr_index,
    input  logic [rmhts_pkg::CFG_DATA_W-1:0]        wr_data,
    output rmhts_pkg::cfg_t                         cfg
);
    import rmhts_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_WORK_MODE:      cfg_next.work_mode      = wr_data[0];
                REG_STEP_LIMIT:     cfg_next.step_limit     = wr_data;
                REG_PAUSE_POSITION: cfg_next.pause_position = wr_data[7:0];
                REG_PAUSE_ONE_MS:   cfg_next.pause_one_ms   = wr_data;
                REG_PAUSE_TWO_MS:   cfg_next.pause_two_ms   = wr_data;
                REG_HOUR_BEGIN:     cfg_next.hour_begin     = wr_data[4:0];
                REG_HOUR_END:       cfg_next.hour_end       = wr_data[4:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.work_mode      <= 1'b0;
            cfg_reg.step_limit     <= 16'd500;
            cfg_reg.pause_position <= 8'd0;
            cfg_reg.pause_one_ms   <= 16'd1000;
            cfg_reg.pause_two_ms   <= 16'd2000;
            cfg_reg.hour_begin     <= 5'd8;
            cfg_reg.hour_end       <= 5'd22;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[src/rmhts_core.sv]
// Sequencer state and the single-pass next-state logic for one event word.
// Depends on rmhts_pkg for op codes, state encoding and the cmd/rsp/cfg structs.
module rmhts_core
#(
    parameter int unsigned MIN_STEP_GAP     = 50,
    parameter int unsigned HOURS_PER_CIRCLE = 12,
    parameter int unsigned COUNT_BITS       = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              ev_valid,
    input  rmhts_pkg::cmd_t   ev,
    input  rmhts_pkg::cfg_t   cfg,
    output rmhts_pkg::rsp_t   rsp
);
    import rmhts_pkg::*;

    localparam int unsigned WIDE_W = COUNT_BITS + 16;
    localparam logic [WIDE_W-1:0] GAP_WIDE = WIDE_W'(MIN_STEP_GAP);

    // hour modulo the circle, by counting up at elaboration
    function automatic logic [4:0] hour_mod(input int unsigned h);
        int unsigned r;
        r = 0;
        for (int unsigned i = 0; i < h; i++)
        begin
            r = r + 1;
            if (r == HOURS_PER_CIRCLE)
            begin
                r = 0;
            end
        end
        return 5'(r);
    endfunction

    logic [4:0] hour_tbl [32];
    for (genvar g = 0; g < 32; g++)
    begin : g_hour_tbl
        assign hour_tbl[g] = hour_mod(g);
    end

    mode_t                 mode_reg,  mode_next;
    logic [COUNT_BITS-1:0] cnt_reg,   cnt_next;
    logic [COUNT_BITS-1:0] pend_reg,  pend_next;
    logic [COUNT_BITS-1:0] meas_reg,  meas_next;
    logic [4:0]            last_reg,  last_next;
    logic                  en_reg,    en_next;
    logic                  led_reg,   led_next;

    logic                  req;
    logic [15:0]           dly;

    logic [COUNT_BITS-1:0] cnt_inc;
    logic [WIDE_W-1:0]     cnt_wide, inc_wide, lim_wide, pos_wide, turn_wide;
    logic [WIDE_W-1:0]     meas_out, pend_out;
    logic [COUNT_BITS-1:0] turn_load, hour_load;
    logic                  hit_gap, in_window;

    assign cnt_inc   = (cnt_reg == '1) ? cnt_reg : cnt_reg + COUNT_BITS'(1);
    assign cnt_wide  = {{16{1'b0}}, cnt_reg};
    assign inc_wide  = {{16{1'b0}}, cnt_inc};
    assign lim_wide  = {{COUNT_BITS{1'b0}}, cfg.step_limit};
    assign pos_wide  = {{(WIDE_W-8){1'b0}}, cfg.pause_position};
    assign turn_wide = {{COUNT_BITS{1'b0}}, ev.turn_count};
    assign turn_load = turn_wide[COUNT_BITS-1:0];
    assign hour_load = {{(COUNT_BITS-5){1'b0}}, hour_tbl[ev.clock_hour]};
    assign hit_gap   = ev.sensor_hit && (cnt_wide > GAP_WIDE);
    assign in_window = (ev.clock_hour >= cfg.hour_begin) && (ev.clock_hour <= cfg.hour_end);

    always_comb
    begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        pend_next = pend_reg;
        meas_next = meas_reg;
        last_next = last_reg;
        en_next   = en_reg;
        led_next  = led_reg;
        req       = 1'b0;
        dly       = 16'd0;

        if (ev_valid)
        begin
            unique case (ev.operation)
                OP_STEP_DONE:
                begin
                    unique case (mode_reg)
                        S_HOME:
                        begin
                            if (cnt_wide > lim_wide)
                            begin
                                mode_next = S_ERROR;
                                en_next   = 1'b0;
                                led_next  = 1'b0;
                                cnt_next  = '0;
                            end
                            else if (ev.sensor_hit)
                            begin
                                // homed; chain calibration when work mode lacks it
                                if (cfg.work_mode && meas_reg == '0)
                                begin
                                    mode_next = S_CAL;
                                    en_next   = 1'b1;
                                    led_next  = 1'b1;
                                    req       = 1'b1;
                                end
                                else
                                begin
                                    mode_next = S_IDLE;
                                    en_next   = 1'b0;
                                    led_next  = 1'b0;
                                end
                                cnt_next = '0;
                            end
                            else
                            begin
                                cnt_next = cnt_inc;
                                req      = 1'b1;
                            end
                        end
                        S_CAL:
                        begin
                            if (cnt_wide >= lim_wide)
                            begin
                                mode_next = S_ERROR;
                                en_next   = 1'b0;
                                led_next  = 1'b0;
                                cnt_next  = '0;
                            end
                            else if (hit_gap)
                            begin
                                meas_next = cnt_reg;
                                mode_next = S_IDLE;
                                en_next   = 1'b0;
                                led_next  = 1'b0;
                                cnt_next  = '0;
                            end
                            else
                            begin
                                cnt_next = cnt_inc;
                                req      = 1'b1;
                            end
                        end
                        S_TURN:
                        begin
                            if (hit_gap)
                            begin
                                // revolution done: start the next one right away if turns remain, else go idle
                                cnt_next = '0;
                                if (pend_reg != '0)
                                begin
                                    pend_next = pend_reg - COUNT_BITS'(1);
                                    req       = 1'b1;
                                    dly       = cfg.pause_two_ms;
                                end
                                else
                                begin
                                    mode_next = S_IDLE;
                                    en_next   = 1'b0;
                                    led_next  = 1'b0;
                                end
                            end
                            else if (cnt_wide > lim_wide)
                            begin
                                mode_next = S_ERROR;
                                en_next   = 1'b0;
                                led_next  = 1'b0;
                                cnt_next  = '0;
                            end
                            else
                            begin
                                cnt_next = cnt_inc;
                                req      = 1'b1;
                                dly      = (inc_wide == pos_wide) ? cfg.pause_one_ms : 16'd0;
                            end
                        end
                        default:
                        begin
                            mode_next = mode_reg;
                        end
                    endcase
                end
                OP_HOME:
                begin
                    cnt_next = '0;
                    if (!ev.sensor_hit)
                    begin
                        mode_next = S_HOME;
                        en_next   = 1'b1;
                        led_next  = 1'b1;
                        req       = 1'b1;
                    end
                    else if (cfg.work_mode && meas_reg == '0)
                    begin
                        mode_next = S_CAL;
                        en_next   = 1'b1;
                        led_next  = 1'b1;
                        req       = 1'b1;
                    end
                    else
                    begin
                        mode_next = S_IDLE;
                        en_next   = 1'b0;
                        led_next  = 1'b0;
                    end
                end
                OP_CALIBRATE:
                begin
                    mode_next = S_CAL;
                    en_next   = 1'b1;
                    led_next  = 1'b1;
                    cnt_next  = '0;
                    req       = 1'b1;
                end
                OP_TURN:
                begin
                    if (!cfg.work_mode && pend_reg == '0 && ev.turn_count != 16'd0)
                    begin
                        // a busy sequencer only stores the count
                        if (mode_reg == S_IDLE && turn_load != '0)
                        begin
                            pend_next = turn_load - COUNT_BITS'(1);
                            mode_next = S_TURN;
                            en_next   = 1'b1;
                            led_next  = 1'b1;
                            cnt_next  = '0;
                            req       = 1'b1;
                        end
                        else
                        begin
                            pend_next = turn_load;
                        end
                    end
                end
                OP_HOUR_TICK:
                begin
                    if (cfg.work_mode && mode_reg == S_IDLE && in_window
                        && last_reg != ev.clock_hour && ev.clock_minute == 6'd0)
                    begin
                        last_next = ev.clock_hour;
                        if (hour_load != '0)
                        begin
                            pend_next = hour_load - COUNT_BITS'(1);
                            mode_next = S_TURN;
                            en_next   = 1'b1;
                            led_next  = 1'b1;
                            cnt_next  = '0;
                            req       = 1'b1;
                        end
                        else
                        begin
                            pend_next = '0;
                        end
                    end
                end
                OP_RESET:
                begin
                    // driver enable and emitter keep their levels
                    cnt_next  = '0;
                    pend_next = '0;
                    mode_next = S_IDLE;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= S_IDLE;
            cnt_reg  <= '0;
            pend_reg <= '0;
            meas_reg <= '0;
            last_reg <= NO_HOUR;
            en_reg   <= 1'b0;
            led_reg  <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            pend_reg <= pend_next;
            meas_reg <= meas_next;
            last_reg <= last_next;
            en_reg   <= en_next;
            led_reg  <= led_next;
        end
    end

    assign meas_out = {{16{1'b0}}, meas_next};
    assign pend_out = {{16{1'b0}}, pend_next};

    always_comb
    begin
        rsp.step_request   = req;
        rsp.step_delay_ms  = dly;
        rsp.motor_enable   = en_next;
        rsp.sensor_led     = led_next;
        rsp.steps_per_turn = meas_out[15:0];
        rsp.turns_left     = pend_out[15:0];
        unique case (mode_next)
            S_IDLE:  rsp.status = STATUS_IDLE;
            S_HOME:  rsp.status = STATUS_HOME;
            S_CAL:   rsp.status = STATUS_CAL;
            S_TURN:  rsp.status = STATUS_TURN;
            S_ERROR: rsp.status = STATUS_ERROR;
            default: rsp.status = STATUS_IDLE;
        endcase
    end

`ifndef ASSERT_OFF
    // driver enable and emitter always switch together
    a_en_led_tied: assert property (@(posedge clk) disable iff (!rst_n)
        en_reg == led_reg)
        else $error("motor enable and sensor led disagree");

    // a requested step leaves a sequence running with the driver on
    a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && req |=>
            (mode_reg == S_HOME || mode_reg == S_CAL || mode_reg == S_TURN) && en_reg)
        else $error("step requested without a running sequence");

    // reset event clears the sequence state
    a_reset_event: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && ev.operation == OP_RESET |=>
            mode_reg == S_IDLE && cnt_reg == '0 && pend_reg == '0)
        else $error("reset event left sequence state behind");
`endif

endmodule

[src/ring_motor_homing_turn_sequencer.sv]
// Ring motor homing and turn sequencer: event input register, sequencing
// core, configuration bank and result register. Uses rmhts_pkg and rmhts_if.
//
// One event word is accepted per clock unless the result side stalls, and
// each yields exactly one result word, held first in the input register and
// then in the result register. The core's single-pass next-state logic sits
// between those two registers and updates the sequencer state on the same
// edge that captures the result. A stalled result holds the input register;
// cmd.ready stays high while the input register is empty or the result
// register is empty or being taken. Configuration writes land directly in
// the register bank and are meant to happen only while no event is in flight.
module ring_motor_homing_turn_sequencer
#(
    parameter int unsigned MIN_STEP_GAP     = 50,
    parameter int unsigned HOURS_PER_CIRCLE = 12,
    parameter int unsigned COUNT_BITS       = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    rmhts_cmd_if.sink                           cmd,
    rmhts_rsp_if.source                         rsp,
    input  logic                                wr_en,
    input  logic [rmhts_pkg::CFG_INDEX_W-1:0]   wr_index,
    input  logic [rmhts_pkg::CFG_DATA_W-1:0]    wr_data
);
    import rmhts_pkg::*;

    cfg_t cfg;
    cmd_t cmd_word;
    cmd_t cmd_reg;
    rsp_t core_rsp;
    rsp_t rsp_reg;
    logic in_valid_reg,  in_valid_next;
    logic out_valid_reg, out_valid_next;
    logic advance;
    logic take_cmd;

    assign advance  = !out_valid_reg || rsp.ready;
    assign cmd.ready = !in_valid_reg || advance;
    assign take_cmd = cmd.valid && cmd.ready;

    assign cmd_word.operation    = cmd.operation;
    assign cmd_word.sensor_hit   = cmd.sensor_hit;
    assign cmd_word.turn_count   = cmd.turn_count;
    assign cmd_word.clock_hour   = cmd.clock_hour;
    assign cmd_word.clock_minute = cmd.clock_minute;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take_cmd)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_cmd)
        begin
            cmd_reg <= cmd_word;
        end
        if (advance && in_valid_reg)
        begin
            rsp_reg <= core_rsp;
        end
    end

    rmhts_cfg_regs u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    rmhts_core
    #(
        .MIN_STEP_GAP     (MIN_STEP_GAP),
        .HOURS_PER_CIRCLE (HOURS_PER_CIRCLE),
        .COUNT_BITS       (COUNT_BITS)
    )
    u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ev_valid (advance && in_valid_reg),
        .ev       (cmd_reg),
        .cfg      (cfg),
        .rsp      (core_rsp)
    );

    assign rsp.valid          = out_valid_reg;
    assign rsp.step_request   = rsp_reg.step_request;
    assign rsp.step_delay_ms  = rsp_reg.step_delay_ms;
    assign rsp.motor_enable   = rsp_reg.motor_enable;
    assign rsp.sensor_led     = rsp_reg.sensor_led;
    assign rsp.status         = rsp_reg.status;
    assign rsp.steps_per_turn = rsp_reg.steps_per_turn;
    assign rsp.turns_left     = rsp_reg.turns_left;

`ifndef ASSERT_OFF
    // a delay only ever rides on a requested step
    a_delay_with_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && rsp_reg.step_delay_ms != 16'd0 |-> rsp_reg.step_request)
        else $error("step delay without step request");

    // a stalled result word keeps the input register occupied and frozen
    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !rsp.ready && in_valid_reg |=> in_valid_reg && $stable(cmd_reg))
        else $error("input word lost during result stall");

    // every processed word produces a result word on the next edge
    a_word_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_valid_reg |=> out_valid_reg)
        else $error("processed word did not reach the result register");
`endif

endmodule

[tb/testbench.sv]
// Self-checking bench for ring_motor_homing_turn_sequencer: random and directed event
// words, a cycle-free predictor of the sequencer, and a result checker.
// Depends on rmhts_pkg, rmhts_if and the RTL top level.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rmhts_pkg::*;

    localparam int unsigned STEP_GAP_MIN   = 50;
    localparam int unsigned HOURS_PER_RING = 12;
    localparam int unsigned HOLD_CYCLES    = 150;
    localparam int unsigned REPORT_LIMIT   = 10;

    // operation codes the block does not define
    localparam logic [2:0] OP_SPARE_LOW  = 3'd6;
    localparam logic [2:0] OP_SPARE_HIGH = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        wr_en;
    logic [2:0]  wr_index;
    logic [15:0] wr_data;

    rmhts_cmd_if cmd();
    rmhts_rsp_if rsp();

    ring_motor_homing_turn_sequencer dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .rsp      (rsp),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predicted sequencer state
    cfg_t        settings;
    logic [2:0]  seq_mode;
    logic [15:0] step_count;
    logic [15:0] turns_queued;
    logic [15:0] steps_per_rev;
    logic [4:0]  last_tick_hour;
    logic        drive_on;
    logic        led_on;
    logic        step_wanted;
    logic [15:0] step_wait_ms;
    int unsigned runs_begun [5];

    cmd_t        event_backlog [$];
    rsp_t        expected_results [$];
    int unsigned events_queued = 0;
    int unsigned events_sent;
    int unsigned results_seen;
    int unsigned mismatches = 0;
    int unsigned settings_applied = 0;
    int unsigned send_gap;
    int unsigned take_stall;
    int unsigned hold_left;
    int unsigned next_hold_at;

    function automatic cfg_t make_settings(input logic wm, input logic [15:0] limit,
                                           input logic [7:0] pos, input logic [15:0] one_ms,
                                           input logic [15:0] two_ms, input logic [4:0] first_hr,
                                           input logic [4:0] final_hr);
        cfg_t c;
        c.work_mode      = wm;
        c.step_limit     = limit;
        c.pause_position = pos;
        c.pause_one_ms   = one_ms;
        c.pause_two_ms   = two_ms;
        c.hour_begin     = first_hr;
        c.hour_end       = final_hr;
        return c;
    endfunction

    function void reset_predictor();
        settings       = make_settings(1'b0, 16'd500, 8'd0, 16'd1000, 16'd2000, 5'd8, 5'd22);
        seq_mode       = STATUS_IDLE;
        step_count     = '0;
        turns_queued   = '0;
        steps_per_rev  = '0;
        last_tick_hour = NO_HOUR;
        drive_on       = 1'b0;
        led_on         = 1'b0;
        foreach (runs_begun[i])
            runs_begun[i] = 0;
    endfunction

    function void request_step(input logic [15:0] wait_ms);
        step_wanted  = 1'b1;
        step_wait_ms = wait_ms;
    endfunction

    function void open_run(input logic [2:0] mode, input logic [15:0] wait_ms);
        seq_mode   = mode;
        led_on     = 1'b1;
        drive_on   = 1'b1;
        step_count = '0;
        runs_begun[mode]++;
        request_step(wait_ms);
    endfunction

    function void close_run(input logic [2:0] mode);
        seq_mode   = mode;
        led_on     = 1'b0;
        drive_on   = 1'b0;
        step_count = '0;
        if (mode == STATUS_ERROR)
            runs_begun[STATUS_ERROR]++;
    endfunction

    function void start_revolution(input logic [15:0] wait_ms);
        if (seq_mode == STATUS_IDLE && turns_queued != 0)
        begin
            turns_queued--;
            open_run(STATUS_TURN, wait_ms);
        end
    endfunction

    function void home_found();
        close_run(STATUS_IDLE);
        // work mode calibrates right after a successful homing while no turn is measured
        if (settings.work_mode && steps_per_rev == 0)
            open_run(STATUS_CAL, 16'd0);
    endfunction

    function void count_step();
        if (step_count != 16'hFFFF)
            step_count++;
    endfunction

    function void on_step_done(input logic hit);
        case (seq_mode)
            STATUS_HOME:
            begin
                if (step_count > settings.step_limit)
                    close_run(STATUS_ERROR);
                else if (hit)
                    home_found();
                else
                begin
                    count_step();
                    request_step(16'd0);
                end
            end
            STATUS_CAL:
            begin
                if (step_count >= settings.step_limit)
                    close_run(STATUS_ERROR);
                else if (hit && step_count > STEP_GAP_MIN)
                begin
                    steps_per_rev = step_count;
                    close_run(STATUS_IDLE);
                end
                else
                begin
                    count_step();
                    request_step(16'd0);
                end
            end
            STATUS_TURN:
            begin
                // the sensor is checked before the limit while turning
                if (hit && step_count > STEP_GAP_MIN)
                begin
                    close_run(STATUS_IDLE);
                    start_revolution(settings.pause_two_ms);
                end
                else if (step_count > settings.step_limit)
                    close_run(STATUS_ERROR);
                else
                begin
                    count_step();
                    request_step(step_count == {8'd0, settings.pause_position} ?
                                 settings.pause_one_ms : 16'd0);
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function rsp_t predict_result(input cmd_t ev);
        rsp_t r;
        step_wanted  = 1'b0;
        step_wait_ms = '0;
        case (ev.operation)
            OP_STEP_DONE:
                on_step_done(ev.sensor_hit);
            OP_HOME:
            begin
                if (ev.sensor_hit)
                    home_found();
                else
                    open_run(STATUS_HOME, 16'd0);
            end
            OP_CALIBRATE:
                open_run(STATUS_CAL, 16'd0);
            OP_TURN:
            begin
                if (!settings.work_mode && turns_queued == 0 && ev.turn_count != 0)
                begin
                    turns_queued = ev.turn_count;
                    start_revolution(16'd0);
                end
            end
            OP_HOUR_TICK:
            begin
                if (settings.work_mode && seq_mode == STATUS_IDLE
                    && ev.clock_hour >= settings.hour_begin
                    && ev.clock_hour <= settings.hour_end
                    && ev.clock_hour != last_tick_hour && ev.clock_minute == 0)
                begin
                    last_tick_hour = ev.clock_hour;
                    turns_queued   = 16'(ev.clock_hour % HOURS_PER_RING);
                    start_revolution(16'd0);
                end
            end
            OP_RESET:
            begin
                step_count   = '0;
                turns_queued = '0;
                seq_mode     = STATUS_IDLE;
            end
            default:
            begin
            end
        endcase
        r.step_request   = step_wanted;
        r.step_delay_ms  = step_wanted ? step_wait_ms : 16'd0;
        r.motor_enable   = drive_on;
        r.sensor_led     = led_on;
        r.status         = seq_mode;
        r.steps_per_turn = steps_per_rev;
        r.turns_left     = turns_queued;
        return r;
    endfunction

    // mostly short gaps, a few long ones, and stretches with none at all
    function automatic int unsigned pick_gap(input int unsigned progress);
        int unsigned r;
        if ((progress / 200) % 3 == 1)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // sender: offer the backlog one word at a time, hold while stalled
    always @(posedge clk or negedge rst_n)
    begin : sender
        cmd_t taken;
        cmd_t ev;
        if (!rst_n)
        begin
            cmd.valid        <= 1'b0;
            cmd.operation    <= '0;
            cmd.sensor_hit   <= 1'b0;
            cmd.turn_count   <= '0;
            cmd.clock_hour   <= '0;
            cmd.clock_minute <= '0;
            send_gap         <= 0;
            events_sent      <= 0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
            begin
                taken.operation    = cmd.operation;
                taken.sensor_hit   = cmd.sensor_hit;
                taken.turn_count   = cmd.turn_count;
                taken.clock_hour   = cmd.clock_hour;
                taken.clock_minute = cmd.clock_minute;
                expected_results.push_back(predict_result(taken));
                events_sent <= events_sent + 1;
            end
            if (!cmd.valid || cmd.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap  <= send_gap - 1;
                    cmd.valid <= 1'b0;
                end
                else if (event_backlog.size() > 0)
                begin
                    ev = event_backlog.pop_front();
                    cmd.valid        <= 1'b1;
                    cmd.operation    <= ev.operation;
                    cmd.sensor_hit   <= ev.sensor_hit;
                    cmd.turn_count   <= ev.turn_count;
                    cmd.clock_hour   <= ev.clock_hour;
                    cmd.clock_minute <= ev.clock_minute;
                    send_gap         <= pick_gap(events_sent);
                end
                else
                    cmd.valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus a few long holds while the sender keeps offering
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready    <= 1'b0;
            take_stall   <= 0;
            hold_left    <= 0;
            next_hold_at <= 200;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp.ready <= 1'b0;
        end
        else if (results_seen >= next_hold_at && cmd.valid)
        begin
            hold_left    <= HOLD_CYCLES - 1;
            next_hold_at <= next_hold_at + 450;
            rsp.ready    <= 1'b0;
        end
        else if (take_stall > 0)
        begin
            take_stall <= take_stall - 1;
            rsp.ready  <= 1'b0;
        end
        else
        begin
            take_stall <= pick_gap(results_seen);
            rsp.ready  <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("result %0d: %s expected %0d, got %0d", results_seen, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : result_check
        rsp_t want;
        if (!rst_n)
            results_seen <= 0;
        else if (rsp.valid && rsp.ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result %0d: word arrived with nothing expected", results_seen);
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("step_request", 16'(want.step_request), 16'(rsp.step_request));
                check_field("step_delay_ms", want.step_delay_ms, rsp.step_delay_ms);
                check_field("motor_enable", 16'(want.motor_enable), 16'(rsp.motor_enable));
                check_field("sensor_led", 16'(want.sensor_led), 16'(rsp.sensor_led));
                check_field("status", 16'(want.status), 16'(rsp.status));
                check_field("steps_per_turn", want.steps_per_turn, rsp.steps_per_turn);
                check_field("turns_left", want.turns_left, rsp.turns_left);
            end
            results_seen <= results_seen + 1;
        end
    end

    task automatic push_event(input logic [2:0] op, input logic hit, input logic [15:0] count,
                              input logic [4:0] hour, input logic [5:0] minute);
        cmd_t ev;
        ev.operation    = op;
        ev.sensor_hit   = hit;
        ev.turn_count   = count;
        ev.clock_hour   = hour;
        ev.clock_minute = minute;
        event_backlog.push_back(ev);
        if (op != OP_SPARE_LOW && op != OP_SPARE_HIGH)
            events_queued++;
    endtask

    task automatic push_steps(input int unsigned n, input int unsigned hit_pct);
        for (int unsigned i = 0; i < n; i++)
            push_event(OP_STEP_DONE, $urandom_range(0, 99) < hit_pct, 16'($urandom),
                       5'($urandom), 6'($urandom));
    endtask

    task automatic push_revolutions(input int unsigned revs);
        int unsigned n;
        for (int unsigned i = 0; i < revs; i++)
        begin
            n = ($urandom_range(0, 24) == 0) ? $urandom_range(250, 270) : $urandom_range(51, 60);
            push_steps(n, 3);
            push_steps(1, 100);
        end
    endtask

    task automatic push_hour_run();
        logic [4:0] hour;
        logic [5:0] minute;
        if (settings.hour_begin <= settings.hour_end && $urandom_range(0, 3) != 0)
            hour = 5'($urandom_range(settings.hour_end, settings.hour_begin));
        else
            hour = 5'($urandom_range(0, 23));
        minute = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 59)) : 6'd0;
        push_event(OP_HOUR_TICK, 1'($urandom), 16'($urandom), hour, minute);
        push_revolutions($urandom_range(1, 2));
        push_event(OP_RESET, 1'($urandom), 16'($urandom), 5'($urandom), 6'($urandom));
    endtask

    task automatic queue_random_traffic(input int unsigned budget);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned revs;
        stop_at = events_queued + budget;
        while (events_queued < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 18)
            begin
                push_event(OP_HOME, 1'b0, 16'($urandom), 5'($urandom), 6'($urandom));
                push_steps(($urandom_range(0, 3) == 0) ? $urandom_range(0, 70)
                                                       : $urandom_range(0, 15), 0);
                push_steps(1, 100);
            end
            else if (pick < 36)
            begin
                push_event(OP_CALIBRATE, 1'($urandom), 16'($urandom), 5'($urandom),
                           6'($urandom));
                push_steps($urandom_range(40, 70), 8);
                push_steps(1, 100);
            end
            else if (pick < 62)
            begin
                if ($urandom_range(0, 1))
                    push_event(OP_RESET, 1'($urandom), 16'($urandom), 5'($urandom),
                               6'($urandom));
                if (settings.work_mode)
                    push_hour_run();
                else
                begin
                    revs = $urandom_range(1, 3);
                    push_event(OP_TURN, 1'($urandom), 16'(revs), 5'($urandom), 6'($urandom));
                    // sometimes cut the turn short
                    push_revolutions(revs - $urandom_range(0, 1));
                end
            end
            else if (pick < 75)
                push_hour_run();
            else if (pick < 85)
                push_event(OP_RESET, 1'($urandom), 16'($urandom), 5'($urandom), 6'($urandom));
            else
            begin
                for (int unsigned i = $urandom_range(1, 4); i > 0; i--)
                    push_event(3'($urandom_range(0, 7)), 1'($urandom), 16'($urandom),
                               5'($urandom), 6'($urandom));
            end
        end
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [15:0] data);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= index;
        wr_data  <= data;
    endtask

    task automatic apply_settings(input cfg_t c);
        write_reg(REG_WORK_MODE, 16'(c.work_mode));
        write_reg(REG_STEP_LIMIT, c.step_limit);
        write_reg(REG_PAUSE_POSITION, 16'(c.pause_position));
        write_reg(REG_PAUSE_ONE_MS, c.pause_one_ms);
        write_reg(REG_PAUSE_TWO_MS, c.pause_two_ms);
        write_reg(REG_HOUR_BEGIN, 16'(c.hour_begin));
        write_reg(REG_HOUR_END, 16'(c.hour_end));
        @(posedge clk);
        wr_en    <= 1'b0;
        settings = c;
        settings_applied++;
    endtask

    // hold off until every word is through and the pipeline has been quiet a while
    task automatic wait_drained();
        int unsigned quiet;
        quiet = 0;
        while (quiet < 4)
        begin
            @(posedge clk);
            if (event_backlog.size() == 0 && !cmd.valid && expected_results.size() == 0)
                quiet++;
            else
                quiet = 0;
        end
    endtask

    task automatic run_phase(input cfg_t c, input int unsigned budget);
        apply_settings(c);
        queue_random_traffic(budget);
        wait_drained();
    endtask

    initial
    begin
        reset_predictor();
        rst_n            = 1'b0;
        wr_en            = 1'b0;
        wr_index         = '0;
        wr_data          = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // work mode, still uncalibrated
        apply_settings(make_settings(1'b1, 16'd500, 8'd0, 16'd1000, 16'd2000, 5'd8, 5'd22));
        push_event(OP_STEP_DONE, 1'b1, 16'd0, 5'd0, 6'd0);        // idle: nothing to do
        push_event(OP_SPARE_LOW, 1'b1, 16'hFFFF, 5'd31, 6'd63);
        push_event(OP_SPARE_HIGH, 1'b0, 16'd0, 5'd0, 6'd0);
        push_event(OP_TURN, 1'b0, 16'd5, 5'd0, 6'd0);             // blocked by work mode
        push_event(OP_HOUR_TICK, 1'b0, 16'd0, 5'd7, 6'd0);        // before the window
        push_event(OP_HOUR_TICK, 1'b0, 16'd0, 5'd23, 6'd0);       // after the window
        push_event(OP_HOUR_TICK, 1'b0, 16'd0, 5'd12, 6'd1);       // not on the hour
        push_event(OP_HOME, 1'b1, 16'd0, 5'd0, 6'd0);             // homed, calibration follows
        push_event(OP_HOME, 1'b0, 16'd0, 5'd0, 6'd0);             // drop calibration
        push_event(OP_CALIBRATE, 1'b0, 16'd0, 5'd0, 6'd0);        // drop homing
        push_event(OP_RESET, 1'b0, 16'd0, 5'd0, 6'd0);
        push_event(OP_HOUR_TICK, 1'b0, 16'd0, 5'd13, 6'd0);       // one revolution
        push_event(OP_HOUR_TICK, 1'b0, 16'd0, 5'd13, 6'd0);       // busy turning
        push_event(OP_RESET, 1'b0, 16'd0, 5'd0, 6'd0);
        push_event(OP_HOUR_TICK, 1'b0, 16'd0, 5'd13, 6'd0);       // same hour again
        push_event(OP_HOUR_TICK, 1'b0, 16'd0, 5'd12, 6'd0);       // noon: zero revolutions
        push_event(OP_HOUR_TICK, 1'b0, 16'd0, 5'd8, 6'd0);        // first hour of the window
        push_event(OP_RESET, 1'b0, 16'd0, 5'd0, 6'd0);
        queue_random_traffic(150);
        wait_drained();

        apply_settings(make_settings(1'b0, 16'd500, 8'd0, 16'd1000, 16'd2000, 5'd8, 5'd22));
        push_event(OP_TURN, 1'b0, 16'd0, 5'd0, 6'd0);             // zero revolutions
        push_event(OP_CALIBRATE, 1'b0, 16'd0, 5'd0, 6'd0);
        push_event(OP_TURN, 1'b1, 16'hFFFF, 5'd31, 6'd63);        // stored behind calibration
        push_event(OP_TURN, 1'b0, 16'd3, 5'd0, 6'd0);             // already pending
        push_event(OP_HOME, 1'b0, 16'd0, 5'd0, 6'd0);
        push_event(OP_STEP_DONE, 1'b1, 16'd0, 5'd0, 6'd0);        // homed, turns stay pending
        push_event(OP_RESET, 1'b0, 16'd0, 5'd0, 6'd0);
        queue_random_traffic(200);
        wait_drained();

        run_phase(make_settings(1'b0, 16'hFFFF, 8'd255, 16'hFFFF, 16'd1, 5'd0, 5'd23), 200);
        run_phase(make_settings(1'b0, 16'd0, 8'd52, 16'd1, 16'hFFFF, 5'd23, 5'd0), 150);
        run_phase(make_settings(1'b1, 16'd60, 8'd30, 16'd500, 16'd300, 5'd0, 5'd23), 250);
        run_phase(make_settings(1'b0, 16'd45, 8'd10, 16'd123, 16'd456, 5'd5, 5'd5), 150);
        run_phase(make_settings(1'b1, 16'd200, 8'd52, 16'd1, 16'd1, 5'd23, 5'd23), 200);

        $display("Drove %0d event words under %0d register settings, %0d result words checked.",
                 events_sent, settings_applied, results_seen);
        $display("Predicted %0d homings, %0d calibrations, %0d revolutions, %0d limit errors.",
                 runs_begun[STATUS_HOME], runs_begun[STATUS_CAL], runs_begun[STATUS_TURN],
                 runs_begun[STATUS_ERROR]);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Timed out with %0d results outstanding", expected_results.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

[ring_motor_homing_turn_sequencer.f]
src/rmhts_pkg.sv
src/rmhts_if.sv
src/rmhts_cfg_regs.sv
src/rmhts_core.sv
src/ring_motor_homing_turn_sequencer.sv
tb/testbench.sv
